// ----- rtl/multi_led_blink_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi LED blink sequencer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_LED_BLINK_SEQUENCER_MACROS_SVH
`define MULTI_LED_BLINK_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define MLBS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check a property on every edge, reset included.
`define MLBS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`else

`define MLBS_ASSERT(name, clk, rst, prop)
`define MLBS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ----- rtl/mlbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mlbs_pkg
// Shared types, codes and constants of the multi LED blink sequencer.
// ----------------------------------------------------------------------------
package mlbs_pkg;

   localparam int LED_COUNT = 8;            // LEDs actually built, 1..8
   localparam int LED_W     = 8;            // width of the per-LED bit fields
   localparam int TIME_W    = 16;
   localparam int DUTY_W    = 7;
   localparam int EV_W      = 3;
   localparam int MODE_W    = 2;
   localparam int CNT_W     = 8;
   localparam int IDX_W     = 4;
   localparam int CSR_W     = 16;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 16;

   // percent * period fits 23 bits; x / 100 == (x * RECIP) >> RECIP_SHIFT
   localparam int PROD_W      = 23;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
   localparam logic [DUTY_W-1:0]  PCT_FULL = 7'd100;

   localparam logic [CNT_W-1:0] FOREVER_COUNT = 8'd255;
   localparam logic [CNT_W-1:0] ONCE_COUNT    = 8'd1;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
   localparam logic [EV_W-1:0] EV_BLINK_ONCE = 3'd1;
   localparam logic [EV_W-1:0] EV_FLASH      = 3'd2;
   localparam logic [EV_W-1:0] EV_QUARTER    = 3'd3;
   localparam logic [EV_W-1:0] EV_HALF       = 3'd4;

   // manual modes
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OFF    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ON     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_FLASH_PERIOD = 4'd0;
   localparam logic [IDX_W-1:0] REG_BLINK_DUTY   = 4'd1;
   localparam logic [IDX_W-1:0] REG_QUARTER_DUTY = 4'd2;
   localparam logic [IDX_W-1:0] REG_HALF_DUTY    = 4'd3;

   localparam logic [TIME_W-1:0] PERIOD_RESET  = 16'd1000;
   localparam logic [DUTY_W-1:0] BLINK_RESET   = 7'd50;
   localparam logic [DUTY_W-1:0] QUARTER_RESET = 7'd25;
   localparam logic [DUTY_W-1:0] HALF_RESET    = 7'd50;

   typedef struct packed {
      logic [TIME_W-1:0] on_time;
      logic [TIME_W-1:0] off_time;
   } intv_pair_type;

   typedef struct packed {
      intv_pair_type blink;
      intv_pair_type quarter;
      intv_pair_type half;
   } intv_set_type;

   // one item as seen by a single LED
   typedef struct packed {
      logic              tick;
      logic              sel;
      logic [EV_W-1:0]   event_code;
      logic [MODE_W-1:0] manual_mode;
      logic [TIME_W-1:0] elapsed_time;
   } led_cmd_type;

   typedef struct packed {
      logic lit;
      logic busy;
   } led_status_type;

endpackage

// ----- rtl/mlbs_interval.sv -----
// ----------------------------------------------------------------------------
// mlbs_interval
// On and off intervals of each duty register: pct * period / 100.
// ----------------------------------------------------------------------------
module mlbs_interval (
   input  logic                          clock,
   input  logic [mlbs_pkg::TIME_W-1:0]   flash_period,
   input  logic [mlbs_pkg::DUTY_W-1:0]   blink_duty,
   input  logic [mlbs_pkg::DUTY_W-1:0]   quarter_duty,
   input  logic [mlbs_pkg::DUTY_W-1:0]   half_duty,
   output mlbs_pkg::intv_set_type        intv
);
   import mlbs_pkg::*;

   localparam int SLOTS = 3;
   localparam int FULL_W = PROD_W + RECIP_W;

   logic [DUTY_W-1:0] duty_sat  [SLOTS];
   logic [PROD_W-1:0] full_prod;
   logic [PROD_W-1:0] on_prod_in  [SLOTS];
   logic [PROD_W-1:0] off_prod_in [SLOTS];
   logic [PROD_W-1:0] on_prod_ff  [SLOTS];
   logic [PROD_W-1:0] off_prod_ff [SLOTS];
   logic [TIME_W-1:0] on_q  [SLOTS];
   logic [TIME_W-1:0] off_q [SLOTS];

   function automatic logic [TIME_W-1:0] div_pct(input logic [PROD_W-1:0] x);
      logic [FULL_W-1:0] p;
      p = FULL_W'(x) * FULL_W'(RECIP);
      return p[RECIP_SHIFT +: TIME_W];
   endfunction

   always_comb begin
      duty_sat[0] = blink_duty;
      duty_sat[1] = quarter_duty;
      duty_sat[2] = half_duty;
      full_prod = PROD_W'(flash_period) * PROD_W'(PCT_FULL);
      for (int k = 0; k < SLOTS; k++) begin
         if (duty_sat[k] > PCT_FULL) begin
            duty_sat[k] = PCT_FULL;
         end
         on_prod_in[k]  = PROD_W'(duty_sat[k]) * PROD_W'(flash_period);
         off_prod_in[k] = full_prod - on_prod_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS; k++) begin
         on_prod_ff[k]  <= on_prod_in[k];
         off_prod_ff[k] <= off_prod_in[k];
      end
   end

   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         on_q[k]  = div_pct(on_prod_ff[k]);
         off_q[k] = div_pct(off_prod_ff[k]);
      end
   end

   assign intv.blink.on_time    = on_q[0];
   assign intv.blink.off_time   = off_q[0];
   assign intv.quarter.on_time  = on_q[1];
   assign intv.quarter.off_time = off_q[1];
   assign intv.half.on_time     = on_q[2];
   assign intv.half.off_time    = off_q[2];

endmodule

// ----- rtl/mlbs_led.sv -----
// ----------------------------------------------------------------------------
// mlbs_led
// State and update logic of one LED: manual drive and blink sequence.
// ----------------------------------------------------------------------------
module mlbs_led (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  mlbs_pkg::led_cmd_type     cmd,
   input  mlbs_pkg::intv_set_type    intv,
   output mlbs_pkg::led_status_type  status_next
);
   import mlbs_pkg::*;

   logic              lit_ff,    lit_in;
   logic [EV_W-1:0]   active_ff, active_in;
   logic [CNT_W-1:0]  rem_ff,    rem_in;
   logic [TIME_W-1:0] cd_ff,     cd_in;
   logic [TIME_W-1:0] on_ff,     on_in;
   logic [TIME_W-1:0] off_ff,    off_in;
   intv_pair_type     pair;

   always_comb begin
      case (cmd.event_code)
         EV_QUARTER: pair = intv.quarter;
         EV_HALF:    pair = intv.half;
         default:    pair = intv.blink;
      endcase
   end

   always_comb begin
      lit_in    = lit_ff;
      active_in = active_ff;
      rem_in    = rem_ff;
      cd_in     = cd_ff;
      on_in     = on_ff;
      off_in    = off_ff;
      if (cmd.tick) begin
         if (active_ff != EV_NONE) begin
            if (cmd.elapsed_time < cd_ff) begin
               cd_in = cd_ff - cmd.elapsed_time;
            end else begin
               if (lit_ff) begin
                  lit_in = 1'b0;
                  cd_in  = off_ff;
                  if (rem_ff != FOREVER_COUNT && rem_ff != '0) begin
                     rem_in = rem_ff - CNT_W'(1);
                  end
               end else begin
                  lit_in = 1'b1;
                  cd_in  = on_ff;
               end
               if (rem_in == '0) begin
                  active_in = EV_NONE;
               end
            end
         end
      end else if (cmd.sel) begin
         if (cmd.event_code == EV_NONE) begin
            case (cmd.manual_mode)
               MODE_OFF:    lit_in = 1'b0;
               MODE_ON:     lit_in = 1'b1;
               MODE_TOGGLE: lit_in = ~lit_ff;
               default:     lit_in = lit_ff;
            endcase
            active_in = EV_NONE;
         end else if (cmd.event_code inside {[EV_BLINK_ONCE:EV_HALF]}
                      && cmd.event_code != active_ff) begin
            active_in = cmd.event_code;
            rem_in    = (cmd.event_code == EV_BLINK_ONCE) ? ONCE_COUNT : FOREVER_COUNT;
            on_in     = pair.on_time;
            off_in    = pair.off_time;
            cd_in     = '0;
            lit_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff    <= 1'b0;
         active_ff <= EV_NONE;
         rem_ff    <= '0;
         cd_ff     <= '0;
      end else if (step) begin
         lit_ff    <= lit_in;
         active_ff <= active_in;
         rem_ff    <= rem_in;
         cd_ff     <= cd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         on_ff  <= on_in;
         off_ff <= off_in;
      end
   end

   assign status_next.lit  = lit_in;
   assign status_next.busy = (active_in != EV_NONE);

endmodule

// ----- rtl/multi_led_blink_sequencer.sv -----
// ----------------------------------------------------------------------------
// multi_led_blink_sequencer
// Up to eight LEDs with manual drive and timed blink sequences.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat is either a set command (tuser = 0) that works on
//   the LEDs in its mask, or a tick (tuser = 1) that carries the time passed.
//   rsp channel: one beat per req beat, in order, with the LED on bits and
//   the sequence busy bits as they stand after that item.
//   csr channel: register writes (index 0 period, 1 blink duty, 2 quarter
//   duty, 3 half duty); csr_ready is always high, other indexes are dropped.
// Flow: a req beat is registered in the input register, then updated into
//   the LED state and the rsp register together, which presents its rsp beat.
//   Throughput: one item per cycle while rsp_tready is high and no register
//   write is settling, set by the per-LED update that all LEDs run in parallel.
// The interval products are registered behind the csr registers, so req_tready
//   drops for one cycle after each register write and after reset.
// Reset: all LEDs off, no sequence, registers back to their defaults.
// Stall: when rsp_tready is low the rsp register holds, one more item waits in
//   the input register, and then req_tready drops.
// ----------------------------------------------------------------------------
`include "multi_led_blink_sequencer_macros.svh"

module multi_led_blink_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: led_mask[7:0], event_code[10:8], manual_mode[12:11],
   //            elapsed_time[28:13], zero[31:29]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [mlbs_pkg::REQ_W-1:0]   req_tdata,
   // req_tuser: kind[0]
   input  logic                         req_tuser,
   // rsp_tdata: led_lit[7:0], sequence_busy[15:8]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mlbs_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mlbs_pkg::IDX_W-1:0]   csr_index,
   input  logic [mlbs_pkg::CSR_W-1:0]   csr_data
);
   import mlbs_pkg::*;

   // configuration registers
   logic [TIME_W-1:0] period_ff;
   logic [DUTY_W-1:0] blink_ff, quarter_ff, half_ff;
   logic              hold_ff;           // blocks req while intervals settle
   logic              csr_fire;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff;
   logic [LED_W-1:0]  in_mask_ff;
   logic [EV_W-1:0]   in_event_ff;
   logic [MODE_W-1:0] in_mode_ff;
   logic [TIME_W-1:0] in_elapsed_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [LED_W-1:0]  out_lit_ff, out_busy_ff;
   logic [LED_W-1:0]  lit_next, busy_next;

   logic              req_fire;
   logic              advance;
   intv_set_type      intv;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   // Write the addressed register; drop unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         blink_ff   <= BLINK_RESET;
         quarter_ff <= QUARTER_RESET;
         half_ff    <= HALF_RESET;
         hold_ff    <= 1'b1;
      end else begin
         hold_ff <= csr_fire;
         if (csr_fire) begin
            case (csr_index)
               REG_FLASH_PERIOD: period_ff  <= csr_data;
               REG_BLINK_DUTY:   blink_ff   <= csr_data[DUTY_W-1:0];
               REG_QUARTER_DUTY: quarter_ff <= csr_data[DUTY_W-1:0];
               REG_HALF_DUTY:    half_ff    <= csr_data[DUTY_W-1:0];
               default:          ;
            endcase
         end
      end
   end

   mlbs_interval u_interval (
      .clock        (clock),
      .flash_period (period_ff),
      .blink_duty   (blink_ff),
      .quarter_duty (quarter_ff),
      .half_duty    (half_ff),
      .intv         (intv)
   );

   // Advance the held item whenever the result register is free or draining.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = (~in_valid_ff | advance) & ~hold_ff;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the req beat fields.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff    <= req_tuser;
         in_mask_ff    <= req_tdata[7:0];
         in_event_ff   <= req_tdata[10:8];
         in_mode_ff    <= req_tdata[12:11];
         in_elapsed_ff <= req_tdata[28:13];
      end
   end

   // One update unit per built LED; missing LEDs stay dark and idle.
   for (genvar i = 0; i < LED_W; i++) begin : g_led
      if (i < LED_COUNT) begin : g_on
         led_cmd_type    cmd;
         led_status_type status_next;

         assign cmd.tick         = in_kind_ff;
         assign cmd.sel          = in_mask_ff[i];
         assign cmd.event_code   = in_event_ff;
         assign cmd.manual_mode  = in_mode_ff;
         assign cmd.elapsed_time = in_elapsed_ff;

         mlbs_led u_led (
            .clock       (clock),
            .reset       (reset),
            .step        (advance),
            .cmd         (cmd),
            .intv        (intv),
            .status_next (status_next)
         );

         assign lit_next[i]  = status_next.lit;
         assign busy_next[i] = status_next.busy;
      end else begin : g_off
         assign lit_next[i]  = 1'b0;
         assign busy_next[i] = 1'b0;
      end
   end

   // Load the result beat alongside the state update.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_lit_ff  <= lit_next;
         out_busy_ff <= busy_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_busy_ff, out_lit_ff};

   // A register write keeps req closed for the following cycle.
   `MLBS_ASSERT(a_hold_after_csr, clock, reset, csr_fire |=> !req_tready)
   // A held item stays put while the result register is stalled.
   `MLBS_ASSERT(a_item_kept, clock, reset,
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> in_valid_ff)
   // A drained result with nothing behind it empties the result register.
   `MLBS_ASSERT(a_rsp_drain, clock, reset,
      (rsp_tvalid && rsp_tready && !advance) |=> !rsp_tvalid)
   // Reset leaves no result pending and the req side closed.
   `MLBS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_tvalid && !req_tready))

endmodule
